[rtl/psched_pkg.sv]
// Package for the preemptive priority scheduler.
// Holds table sizes, codes, request/response types and the structs between modules.
// No dependencies.
`default_nettype none

package psched_pkg;

   localparam int MAX_JOBS   = 16;
   localparam int PRIO_BITS  = 8;
   localparam int BURST_BITS = 16;
   localparam int SLOT_BITS  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_RAN      = 2'd0,
      STATUS_IDLE     = 2'd1,
      STATUS_ACCEPTED = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  job_id;
      logic [7:0]  job_priority;
      logic [15:0] job_burst;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  run_id;
      logic        finished;
      logic        first_run;
      logic [31:0] now_ms;
      logic [31:0] turnaround_ms;
      logic [31:0] waiting_ms;
      logic [31:0] response_ms;
   } rsp_type;

   typedef struct packed {
      logic [7:0]            job;
      logic [PRIO_BITS-1:0]  prio;
      logic [BURST_BITS-1:0] left;
      logic [BURST_BITS-1:0] length;
      logic [31:0]           arrived;
      logic [31:0]           began;
   } entry_type;

   typedef struct packed {
      logic                 clear;
      logic                 step;
      logic [SLOT_BITS-1:0] idx;
   } pick_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] best_idx;
      entry_type            best;
      logic [31:0]          best_age;
      logic                 free_found;
      logic [SLOT_BITS-1:0] free_idx;
   } pick_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      logic                 valid;
      entry_type            entry;
   } tbl_wr_type;

endpackage

`default_nettype wire

[rtl/psched_table.sv]
// Job table: memory of slot entries with one read and one write port, plus per-slot valid flags.
// Depends on psched_pkg.
`default_nettype none

module psched_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [psched_pkg::SLOT_BITS-1:0] rd_addr,
   input  psched_pkg::tbl_wr_type         tbl_wr,
   output psched_pkg::entry_type          rd_entry,
   output logic                           rd_valid
);
   import psched_pkg::*;

   entry_type             mem [MAX_JOBS];
   entry_type             rd_entry_ff;
   logic [MAX_JOBS-1:0]   valid_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         mem[tbl_wr.addr] <= tbl_wr.entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (tbl_wr.en) begin
            valid_ff[tbl_wr.addr] <= tbl_wr.valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

[rtl/psched_pick.sv]
// Shared compare unit: judges one table entry per cycle against the best so far
// and tracks the lowest free slot. Depends on psched_pkg.
`default_nettype none

module psched_pick (
   input  logic                     clock,
   input  logic                     reset,
   input  psched_pkg::pick_ctl_type pick_ctl,
   input  logic [31:0]              now_ms,
   input  psched_pkg::entry_type    rd_entry,
   input  logic                     rd_valid,
   output psched_pkg::pick_type     pick
);
   import psched_pkg::*;

   pick_type    pick_ff;
   pick_type    pick_in;
   logic [31:0] age;
   logic        take;

   assign age  = now_ms - rd_entry.arrived;
   assign take = pick_ctl.step && rd_valid &&
                 (!pick_ff.found || (rd_entry.prio < pick_ff.best.prio) ||
                  ((rd_entry.prio == pick_ff.best.prio) && (age > pick_ff.best_age)));

   always_comb begin
      pick_in = pick_ff;
      if (pick_ctl.clear) begin
         pick_in = '0;
      end else begin
         if (take) begin
            pick_in.found    = 1'b1;
            pick_in.best_idx = pick_ctl.idx;
            pick_in.best     = rd_entry;
            pick_in.best_age = age;
         end
         if (pick_ctl.step && !rd_valid && !pick_ff.free_found) begin
            pick_in.free_found = 1'b1;
            pick_in.free_idx   = pick_ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff <= '0;
      end else begin
         pick_ff <= pick_in;
      end
   end

   assign pick = pick_ff;

endmodule

`default_nettype wire

[rtl/psched_seq.sv]
// Sequencer: walks the table one slot per cycle, then applies the request,
// updates the table and, on a tick, the millisecond counter, and registers the response.
// Depends on psched_pkg.
`default_nettype none

module psched_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  psched_pkg::req_type              req_data,
   input  psched_pkg::pick_type             pick,
   output logic [psched_pkg::SLOT_BITS-1:0] rd_addr,
   output psched_pkg::pick_ctl_type         pick_ctl,
   output psched_pkg::tbl_wr_type           tbl_wr,
   output logic [31:0]                      now_ms,
   output logic                             rsp_strobe,
   output psched_pkg::rsp_type              rsp_data
);
   import psched_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pidx_ff, pidx_in;
   req_type              req_ff, req_in;
   logic [31:0]          now_ff, now_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                  issue;
   logic                  scan_done;
   logic [15:0]           prio_ext;
   logic [31:0]           burst_ext;
   logic [PRIO_BITS-1:0]  new_prio;
   logic [BURST_BITS-1:0] new_burst;
   logic                  accept_ok;
   logic                  run_first;
   logic [31:0]           began;
   logic [BURST_BITS-1:0] left_next;
   logic                  run_done;
   logic [31:0]           tat_ms;
   logic [31:0]           wait_ms;
   logic [31:0]           resp_ms;

   assign issue     = cnt_ff < CNT_BITS'(MAX_JOBS);
   assign scan_done = cnt_ff == CNT_BITS'(MAX_JOBS);

   assign prio_ext  = 16'(req_ff.job_priority);
   assign burst_ext = 32'(req_ff.job_burst);
   assign new_prio  = prio_ext[PRIO_BITS-1:0];
   assign new_burst = burst_ext[BURST_BITS-1:0];
   assign accept_ok = (new_burst != '0) && pick.free_found;

   assign run_first = pick.best.left == pick.best.length;
   assign began     = run_first ? now_ff : pick.best.began;
   assign left_next = pick.best.left - BURST_BITS'(1);
   assign run_done  = left_next == '0;
   assign tat_ms    = pick.best_age + 32'd1;
   assign wait_ms   = tat_ms - 32'(pick.best.length);
   assign resp_ms   = began - pick.best.arrived;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy          = state_ff != ST_IDLE;
      rd_addr       = cnt_ff[SLOT_BITS-1:0];
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pidx_in       = cnt_ff[SLOT_BITS-1:0];
      req_in        = req_ff;
      now_in        = now_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      tbl_wr        = '0;
      pick_ctl      = '0;
      pick_ctl.step = pend_ff;
      pick_ctl.idx  = pidx_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               req_in         = req_data;
               pick_ctl.clear = 1'b1;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in  = cnt_ff + CNT_BITS'(1);
               pend_in = 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            rsp_in.now_ms = now_ff;
            if (req_ff.opcode == OP_ARRIVAL) begin
               rsp_in.run_id       = req_ff.job_id;
               rsp_in.status       = accept_ok ? STATUS_ACCEPTED : STATUS_REJECTED;
               tbl_wr.en           = accept_ok;
               tbl_wr.addr         = pick.free_idx;
               tbl_wr.valid        = 1'b1;
               tbl_wr.entry.job    = req_ff.job_id;
               tbl_wr.entry.prio   = new_prio;
               tbl_wr.entry.left   = new_burst;
               tbl_wr.entry.length = new_burst;
               tbl_wr.entry.arrived = now_ff;
               tbl_wr.entry.began  = '0;
            end else begin
               now_in = now_ff + 32'd1;
               if (pick.found) begin
                  rsp_in.status    = STATUS_RAN;
                  rsp_in.run_id    = pick.best.job;
                  rsp_in.first_run = run_first;
                  rsp_in.finished  = run_done;
                  if (run_done) begin
                     rsp_in.turnaround_ms = tat_ms;
                     rsp_in.waiting_ms    = wait_ms;
                     rsp_in.response_ms   = resp_ms;
                  end
                  tbl_wr.en          = 1'b1;
                  tbl_wr.addr        = pick.best_idx;
                  tbl_wr.valid       = !run_done;
                  tbl_wr.entry       = pick.best;
                  tbl_wr.entry.left  = left_next;
                  tbl_wr.entry.began = began;
               end else begin
                  rsp_in.status = STATUS_IDLE;
               end
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         now_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         now_ff        <= now_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   assign now_ms     = now_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

[rtl/preemptive_priority_scheduler_top.sv]
// Top level of the preemptive priority scheduler.
// Instantiates psched_seq, psched_pick and psched_table; depends on psched_pkg.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start is high and busy is low
//   response  rsp_strobe, rsp_data       shown one cycle under rsp_strobe
//
// A request walks all MAX_JOBS table slots through one compare unit, one slot
// per cycle from a single memory read port, then updates in a finish state.
// The response is registered in the finish state; busy drops in the same cycle
// as the strobe, so a new request is taken no sooner than the response shows.
// Reset clears the valid flags, the millisecond counter and the sequencer.
// The response cannot be held off; it is valid for exactly its strobe cycle.
`default_nettype none

module preemptive_priority_scheduler_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  psched_pkg::req_type req_data,
   output logic                rsp_strobe,
   output psched_pkg::rsp_type rsp_data
);
   import psched_pkg::*;

   logic [SLOT_BITS-1:0] rd_addr;
   entry_type            rd_entry;
   logic                 rd_valid;
   tbl_wr_type           tbl_wr;
   pick_ctl_type         pick_ctl;
   pick_type             pick;
   logic [31:0]          now_ms;

   psched_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .pick       (pick),
      .rd_addr    (rd_addr),
      .pick_ctl   (pick_ctl),
      .tbl_wr     (tbl_wr),
      .now_ms     (now_ms),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   psched_pick u_pick (
      .clock    (clock),
      .reset    (reset),
      .pick_ctl (pick_ctl),
      .now_ms   (now_ms),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid),
      .pick     (pick)
   );

   psched_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .tbl_wr   (tbl_wr),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

endmodule

`default_nettype wire

[rtl/psched_checker.sv]
// Port-level checker for the preemptive priority scheduler, bound to the top.
// Depends on psched_pkg and preemptive_priority_scheduler_top.
`default_nettype none

module psched_assert (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input psched_pkg::rsp_type rsp_data
);
   import psched_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("request finished without a response");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy ##1 !rsp_strobe))
      else $error("response strobe repeated or shown while busy");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == STATUS_IDLE)) |->
      ((rsp_data.run_id == 8'd0) && !rsp_data.finished && !rsp_data.first_run))
      else $error("idle tick reported a job");

   a_arrival_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_data.status == STATUS_ACCEPTED) ||
                      (rsp_data.status == STATUS_REJECTED))) |->
      (!rsp_data.finished && !rsp_data.first_run))
      else $error("arrival response reported a run");

endmodule

bind preemptive_priority_scheduler_top psched_assert u_psched_assert (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

[verif/psched_checker.sv]
// Response checker for the preemptive priority scheduler: predicts every response from
// the requests it sees taken and compares them in order. Depends on psched_pkg only.
module psched_checker
   import psched_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      ran_count,
   output int      done_count,
   output int      idle_count,
   output int      reject_count
);

   logic                  held       [MAX_JOBS];
   logic [7:0]            owner      [MAX_JOBS];
   logic [PRIO_BITS-1:0]  rank       [MAX_JOBS];
   logic [BURST_BITS-1:0] remaining  [MAX_JOBS];
   logic [BURST_BITS-1:0] length     [MAX_JOBS];
   logic [31:0]           arrived_at [MAX_JOBS];
   logic [31:0]           started_at [MAX_JOBS];
   logic [31:0]           clock_ms;

   rsp_type expected_rsp[$];
   int      errors;
   int      ran, done, idle, rejected;

   initial begin
      fail_count   = 0;
      pending      = 0;
      ran_count    = 0;
      done_count   = 0;
      idle_count   = 0;
      reject_count = 0;
      errors       = 0;
      ran          = 0;
      done         = 0;
      idle         = 0;
      rejected     = 0;
      clock_ms     = '0;
      foreach (held[i]) held[i] = 1'b0;
   end

   function automatic rsp_type run_scheduler(input req_type r);
      rsp_type               o;
      int                    free_slot;
      int                    pick;
      logic [31:0]           now;
      logic [31:0]           age;
      logic [31:0]           best_age;
      logic [PRIO_BITS-1:0]  best_prio;
      logic [PRIO_BITS-1:0]  prio;
      logic [BURST_BITS-1:0] burst;
      o = '0;
      now = clock_ms;
      o.now_ms = now;
      if (r.opcode == OP_ARRIVAL) begin
         prio = r.job_priority;
         burst = r.job_burst;
         free_slot = -1;
         for (int i = MAX_JOBS - 1; i >= 0; i--) begin
            if (!held[i]) free_slot = i;
         end
         o.run_id = r.job_id;
         if (burst == '0 || free_slot < 0) begin
            o.status = STATUS_REJECTED;
         end else begin
            held[free_slot]       = 1'b1;
            owner[free_slot]      = r.job_id;
            rank[free_slot]       = prio;
            remaining[free_slot]  = burst;
            length[free_slot]     = burst;
            arrived_at[free_slot] = now;
            started_at[free_slot] = '0;
            o.status = STATUS_ACCEPTED;
         end
      end else begin
         pick = -1;
         best_prio = '0;
         best_age = '0;
         for (int i = 0; i < MAX_JOBS; i++) begin
            if (held[i]) begin
               age = now - arrived_at[i];
               if (pick < 0 || rank[i] < best_prio || (rank[i] == best_prio && age > best_age)) begin
                  pick = i;
                  best_prio = rank[i];
                  best_age = age;
               end
            end
         end
         clock_ms = now + 32'd1;
         if (pick < 0) begin
            o.status = STATUS_IDLE;
         end else begin
            o.status = STATUS_RAN;
            o.run_id = owner[pick];
            if (remaining[pick] == length[pick]) begin
               o.first_run = 1'b1;
               started_at[pick] = now;
            end
            remaining[pick] = remaining[pick] - 1'b1;
            if (remaining[pick] == '0) begin
               o.finished      = 1'b1;
               o.turnaround_ms = now + 32'd1 - arrived_at[pick];
               o.waiting_ms    = o.turnaround_ms - 32'(length[pick]);
               o.response_ms   = started_at[pick] - arrived_at[pick];
               held[pick]      = 1'b0;
            end
         end
      end
      return o;
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (held[i]) held[i] = 1'b0;
         clock_ms = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("run_id", 32'(want.run_id), 32'(rsp_data.run_id));
               compare_field("finished", 32'(want.finished), 32'(rsp_data.finished));
               compare_field("first_run", 32'(want.first_run), 32'(rsp_data.first_run));
               compare_field("now_ms", want.now_ms, rsp_data.now_ms);
               compare_field("turnaround_ms", want.turnaround_ms, rsp_data.turnaround_ms);
               compare_field("waiting_ms", want.waiting_ms, rsp_data.waiting_ms);
               compare_field("response_ms", want.response_ms, rsp_data.response_ms);
               case (want.status)
                  STATUS_RAN: begin
                     ran++;
                     if (want.finished) done++;
                  end
                  STATUS_IDLE:     idle++;
                  STATUS_REJECTED: rejected++;
                  default: ;
               endcase
            end
         end
         if (start && !busy) expected_rsp.push_back(run_scheduler(req_data));
      end
      fail_count   <= errors;
      pending      <= expected_rsp.size();
      ran_count    <= ran;
      done_count   <= done;
      idle_count   <= idle;
      reject_count <= rejected;
   end

endmodule

[verif/tb.sv]
// Testbench top for preemptive_priority_scheduler_top: drives directed and random
// arrival/tick requests and gives the verdict. Depends on psched_pkg, psched_checker and the top.
module tb;
   import psched_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int fail_count, pending, ran_count, done_count, idle_count, reject_count;
   int requests_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   preemptive_priority_scheduler_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   psched_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .ran_count    (ran_count),
      .done_count   (done_count),
      .idle_count   (idle_count),
      .reject_count (reject_count)
   );

   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   task automatic job_arrival(input logic [7:0] id, input logic [7:0] prio,
                              input logic [15:0] burst);
      req_type r;
      r.opcode = OP_ARRIVAL;
      r.job_id = id;
      r.job_priority = prio;
      r.job_burst = burst;
      send_request(r);
   endtask

   task automatic one_tick();
      req_type r;
      r = '0;
      r.opcode = OP_TICK;
      send_request(r);
   endtask

   task automatic hold_off(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic req_type random_request(input int arrival_pct);
      req_type r;
      int      pick;
      r.opcode = ($urandom_range(99) < arrival_pct) ? OP_ARRIVAL : OP_TICK;
      r.job_id = 8'($urandom_range(255));
      r.job_priority = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 5) r.job_burst = '0;
      else if (pick < 85) r.job_burst = 16'($urandom_range(1, 6));
      else r.job_burst = 16'($urandom_range(1, 200));
      return r;
   endfunction

   initial begin
      int arrival_pct;
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      one_tick();
      job_arrival(8'hFF, 8'hFF, 16'h0000);
      job_arrival(8'h01, 8'h05, 16'h0002);
      job_arrival(8'h02, 8'h05, 16'h0001);
      one_tick();
      job_arrival(8'h03, 8'h00, 16'h0001);
      one_tick();
      one_tick();
      one_tick();
      one_tick();
      job_arrival(8'h00, 8'hFF, 16'hFFFF);
      for (int i = 1; i < MAX_JOBS; i++) job_arrival(8'(16 + i), 8'(i % 4), 16'((i % 3) + 1));
      job_arrival(8'h55, 8'h00, 16'h0003);
      drain();

      arrival_pct = 50;
      for (int n = 0; n < 1500; n++) begin
         if (n % 100 == 0) arrival_pct = $urandom_range(25, 75);
         if (n % 500 == 499) drain();
         send_request(random_request(arrival_pct));
         if (n < 600 || n >= 900) hold_off(20);
      end
      start <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);

      $display("Sent %0d requests: %0d job ticks with %0d completions, %0d idle ticks,",
               requests_sent, ran_count, done_count, idle_count);
      $display("%0d rejected arrivals, %0d responses still outstanding.",
               reject_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
